@@ design/irsu_pkg.sv @@
// Shared types, codes and helper functions of the I2C register access sequencer.
`timescale 1ns / 1ps
`default_nettype none
package irsu_pkg;

	// Operation codes carried by a command transaction.
	localparam logic [1:0] OP_RAW_READ  = 2'd0;
	localparam logic [1:0] OP_RAW_WRITE = 2'd1;
	localparam logic [1:0] OP_REG_READ  = 2'd2;
	localparam logic [1:0] OP_REG_WRITE = 2'd3;

	// Input transaction kinds.
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_RESP = 1'b1;

	// Result kinds.
	localparam logic [1:0] OUT_BUS_WRITE = 2'd0;
	localparam logic [1:0] OUT_BUS_READ  = 2'd1;
	localparam logic [1:0] OUT_FINISHED  = 2'd2;

	// Completion codes.
	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_NACK    = 2'd1;
	localparam logic [1:0] ERR_TIMEOUT = 2'd2;
	localparam logic [1:0] ERR_BUSY    = 2'd3;

	// Register offsets inside the I2C master.
	localparam logic [7:0] OFS_DATA_LO = 8'h40;
	localparam logic [7:0] OFS_RX_LO   = 8'h44;
	localparam logic [7:0] OFS_CTRL    = 8'h48;
	localparam logic [7:0] OFS_STATUS  = 8'h4c;
	localparam logic [7:0] OFS_DATA_HI = 8'h54;
	localparam logic [7:0] OFS_RX_HI   = 8'h58;

	// Configuration register map.
	localparam logic [1:0] CFG_ADDR_POLL_LIMIT = 2'd0;
	localparam logic [7:0] POLL_LIMIT_RESET    = 8'd100;

	// Depth of the job queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		J_FINISH,
		J_READ,
		J_CMD
	} job_kind_t;

	// One unit of work for the back: a finish, a single bus read, or a
	// transfer start (optional data writes, control write, status read).
	typedef struct packed {
		job_kind_t   jkind;
		logic        has_lo;
		logic        has_hi;
		logic [7:0]  offset;
		logic [15:0] ctrl;
		logic [31:0] data;
		logic [1:0]  err;
	} job_t;

	function automatic logic [15:0] ctrl_word(input logic rd, input logic [2:0] bytes,
		input logic [6:0] addr);
		ctrl_word = {1'b0, addr, 1'b1, 2'b00, bytes[2] | rd, bytes[1:0], 2'b00};
	endfunction

	function automatic logic [15:0] read_mask(input logic [2:0] bytes);
		read_mask = bytes[0] ? 16'h00ff : 16'hffff;
	endfunction

endpackage
`default_nettype wire

@@ design/irsu_if.sv @@
// Channel interfaces for input transactions and result transactions.
`timescale 1ns / 1ps
`default_nettype none
interface irsu_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [1:0]  op;
	logic [2:0]  byte_count;
	logic [6:0]  i2c_addr;
	logic        conv_sel;
	logic [4:0]  reg_index;
	logic [31:0] wdata;
	logic [31:0] rdata;

	modport source (output valid, kind, op, byte_count, i2c_addr, conv_sel, reg_index,
		wdata, rdata, input ready);
	modport sink (input valid, kind, op, byte_count, i2c_addr, conv_sel, reg_index,
		wdata, rdata, output ready);
endinterface

interface irsu_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  bus_offset;
	logic [15:0] bus_wdata;
	logic [1:0]  error;
	logic [31:0] result_data;
	logic        last;

	modport source (output valid, out_kind, bus_offset, bus_wdata, error, result_data,
		last, input ready);
	modport sink (input valid, out_kind, bus_offset, bus_wdata, error, result_data,
		last, output ready);
endinterface
`default_nettype wire

@@ design/irsu_queue.sv @@
// Short job queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module irsu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire irsu_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop_ready,
	output logic               pop_valid,
	output irsu_pkg::job_t     pop_job
);
	import irsu_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_ready && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ design/irsu_front.sv @@
// Front: accepts transactions, tracks the transfer phase and emits jobs.
`timescale 1ns / 1ps
`default_nettype none
module irsu_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	irsu_item_if.sink       item,
	input  wire logic [7:0] poll_limit,
	input  wire logic       queue_full,
	output logic            push_valid,
	output irsu_pkg::job_t  push_job
);
	import irsu_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_STATUS,
		PH_LOW,
		PH_HIGH
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  poll_count_q, poll_count_n;
	logic [1:0]  pending_op_q, pending_op_n;
	logic [2:0]  pending_bytes_q, pending_bytes_n;
	logic [6:0]  pending_addr_q, pending_addr_n;
	logic [31:0] low_word_q;
	logic        accept;
	logic        want_push;
	job_t        job;
	logic [6:0]  eff_addr;
	logic [2:0]  eff_bytes;
	logic [31:0] wd_shift;
	logic [7:0]  busy_count;
	logic [31:0] rx_masked;

	assign item.ready = !queue_full;
	assign accept     = item.valid && item.ready;
	assign push_valid = accept && want_push;
	assign push_job   = job;

	// Register operations address the converter through a fixed window.
	assign eff_addr   = item.op[1] ? {1'b1, item.conv_sel, item.reg_index} : item.i2c_addr;
	assign eff_bytes  = item.op[1] ? (item.op[0] ? 3'd3 : 3'd2) : item.byte_count;
	assign wd_shift   = (item.op == OP_REG_WRITE) ? {item.wdata[23:0], 8'h00} : item.wdata;
	assign busy_count = poll_count_q + 8'd1;
	assign rx_masked  = {16'h0000, item.rdata[15:0] & read_mask(pending_bytes_q)};

	always_comb begin
		phase_n         = phase_q;
		poll_count_n    = poll_count_q;
		pending_op_n    = pending_op_q;
		pending_bytes_n = pending_bytes_q;
		pending_addr_n  = pending_addr_q;
		want_push       = 1'b1;
		job             = '{jkind: J_FINISH, has_lo: 1'b0, has_hi: 1'b0, offset: 8'h00,
			ctrl: 16'h0000, data: 32'h0, err: ERR_OK};

		if (item.kind == KIND_CMD) begin
			if (phase_q != PH_IDLE) begin
				job.err = ERR_BUSY;
			end else begin
				poll_count_n    = 8'd0;
				pending_op_n    = item.op;
				pending_bytes_n = eff_bytes;
				pending_addr_n  = eff_addr;
				job.jkind       = J_CMD;
				case (item.op)
					OP_RAW_READ: begin
						job.ctrl = ctrl_word(1'b1, eff_bytes, eff_addr);
						phase_n  = PH_STATUS;
					end
					OP_REG_READ: begin
						// Pointer write of one zero byte before the actual read.
						job.has_lo = 1'b1;
						job.ctrl   = ctrl_word(1'b0, 3'd1, eff_addr);
						phase_n    = PH_PRE;
					end
					default: begin
						job.has_lo = 1'b1;
						job.has_hi = (eff_bytes > 3'd2);
						job.data   = wd_shift;
						job.ctrl   = ctrl_word(1'b0, eff_bytes, eff_addr);
						phase_n    = PH_STATUS;
					end
				endcase
			end
		end else begin
			case (phase_q)
				PH_PRE, PH_STATUS: begin
					if (item.rdata[0]) begin
						poll_count_n = busy_count;
						if (busy_count >= poll_limit) begin
							job.err = ERR_TIMEOUT;
							phase_n = PH_IDLE;
						end else begin
							job.jkind  = J_READ;
							job.offset = OFS_STATUS;
						end
					end else if (item.rdata[3]) begin
						job.err = ERR_NACK;
						phase_n = PH_IDLE;
					end else if (phase_q == PH_PRE) begin
						poll_count_n = 8'd0;
						job.jkind    = J_CMD;
						job.ctrl     = ctrl_word(1'b1, pending_bytes_q, pending_addr_q);
						phase_n      = PH_STATUS;
					end else if (pending_op_q == OP_RAW_WRITE ||
						pending_op_q == OP_REG_WRITE) begin
						phase_n = PH_IDLE;
					end else begin
						job.jkind  = J_READ;
						job.offset = OFS_RX_LO;
						phase_n    = PH_LOW;
					end
				end
				PH_LOW: begin
					if (pending_bytes_q > 3'd2) begin
						job.jkind  = J_READ;
						job.offset = OFS_RX_HI;
						phase_n    = PH_HIGH;
					end else begin
						job.data = rx_masked;
						phase_n  = PH_IDLE;
					end
				end
				PH_HIGH: begin
					job.data = low_word_q | {rx_masked[15:0], 16'h0000};
					phase_n  = PH_IDLE;
				end
				default: begin
					// A response with no transfer in flight is dropped.
					want_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			poll_count_q    <= 8'd0;
			pending_op_q    <= OP_RAW_READ;
			pending_bytes_q <= 3'd0;
			pending_addr_q  <= 7'd0;
		end else if (accept) begin
			phase_q         <= phase_n;
			poll_count_q    <= poll_count_n;
			pending_op_q    <= pending_op_n;
			pending_bytes_q <= pending_bytes_n;
			pending_addr_q  <= pending_addr_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_RESP && phase_q == PH_LOW) begin
			low_word_q <= item.rdata;
		end
	end
endmodule
`default_nettype wire

@@ design/irsu_back.sv @@
// Back: expands queued jobs into results, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module irsu_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pop_valid,
	input  wire irsu_pkg::job_t pop_job,
	output logic                pop_ready,
	irsu_result_if.source       result
);
	import irsu_pkg::*;

	// Pending steps of the current job: bit 0 low data write, bit 1 high data
	// write, bit 2 control write, bit 3 status read or the single step.
	job_t        cur_q;
	logic [3:0]  steps_q;
	logic [3:0]  steps_left;
	logic        out_free;
	logic        emit;
	logic        res_valid_q;
	logic [1:0]  res_kind_q, el_kind;
	logic [7:0]  res_offset_q, el_offset;
	logic [15:0] res_wdata_q, el_wdata;
	logic [1:0]  res_err_q, el_err;
	logic [31:0] res_data_q, el_data;
	logic        res_last_q, el_last;

	assign out_free   = !res_valid_q || result.ready;
	assign emit       = (steps_q != 4'd0) && out_free;
	assign steps_left = emit ? (steps_q & (steps_q - 4'd1)) : steps_q;
	assign pop_ready  = (steps_left == 4'd0);
	assign el_last    = ((steps_q & (steps_q - 4'd1)) == 4'd0);

	always_comb begin
		el_kind   = OUT_FINISHED;
		el_offset = 8'h00;
		el_wdata  = 16'h0000;
		el_err    = ERR_OK;
		el_data   = 32'h0;
		case (cur_q.jkind)
			J_CMD: begin
				if (steps_q[0]) begin
					el_kind   = OUT_BUS_WRITE;
					el_offset = OFS_DATA_LO;
					el_wdata  = cur_q.data[15:0];
				end else if (steps_q[1]) begin
					el_kind   = OUT_BUS_WRITE;
					el_offset = OFS_DATA_HI;
					el_wdata  = cur_q.data[31:16];
				end else if (steps_q[2]) begin
					el_kind   = OUT_BUS_WRITE;
					el_offset = OFS_CTRL;
					el_wdata  = cur_q.ctrl;
				end else begin
					el_kind   = OUT_BUS_READ;
					el_offset = OFS_STATUS;
				end
			end
			J_READ: begin
				el_kind   = OUT_BUS_READ;
				el_offset = cur_q.offset;
			end
			default: begin
				el_err  = cur_q.err;
				el_data = cur_q.data;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q     <= 4'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop_ready && pop_valid) begin
				steps_q <= (pop_job.jkind == J_CMD) ?
					{2'b11, pop_job.has_hi, pop_job.has_lo} : 4'b1000;
			end else begin
				steps_q <= steps_left;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			cur_q <= pop_job;
		end
		if (emit) begin
			res_kind_q   <= el_kind;
			res_offset_q <= el_offset;
			res_wdata_q  <= el_wdata;
			res_err_q    <= el_err;
			res_data_q   <= el_data;
			res_last_q   <= el_last;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.out_kind    = res_kind_q;
	assign result.bus_offset  = res_offset_q;
	assign result.bus_wdata   = res_wdata_q;
	assign result.error       = res_err_q;
	assign result.result_data = res_data_q;
	assign result.last        = res_last_q;
endmodule
`default_nettype wire

@@ design/i2c_register_access_sequencer_unit.sv @@
// Top level of the I2C register access sequencer: configuration port and wiring.
`timescale 1ns / 1ps
`default_nettype none
// The first result of a transaction passes the queue, step and result registers.
// Throughput: one input transaction per cycle while the four-entry job queue has room;
// results leave one per cycle when not stalled; a transfer start makes up to four.
// Reset (arst_n low, asynchronous): the sequencer returns to idle, the queue and the
// output register empty, and the poll limit goes back to 100. No clearing pass.
module i2c_register_access_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	irsu_item_if.sink        item,
	irsu_result_if.source    result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import irsu_pkg::*;

	logic [7:0] poll_limit_q;
	logic       cfg_write;
	logic       push_valid;
	job_t       push_job;
	logic       queue_full;
	logic       pop_valid;
	logic       pop_ready;
	job_t       pop_job;

	// The register port never inserts wait states. A write lands in the access
	// phase; only the poll limit register exists, other addresses read as zero.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr == CFG_ADDR_POLL_LIMIT) ? {24'h0, poll_limit_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RESET;
		end else if (cfg_write && paddr == CFG_ADDR_POLL_LIMIT) begin
			poll_limit_q <= pwdata[7:0];
		end
	end

	// The front decides every transaction at acceptance time, so the phase
	// tracking never waits on the output side; the queue absorbs stalls.
	irsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.poll_limit (poll_limit_q),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	irsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.full       (queue_full),
		.pop_ready  (pop_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	// The back walks each job's steps and presents them through a result
	// register, so a new job can load while the last step is still waiting.
	irsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop_ready (pop_ready),
		.result    (result)
	);
endmodule
`default_nettype wire

@@ verif/i2c_register_access_sequencer_unit_checker.sv @@
// Checker for the I2C register access sequencer: predicts every bus access and compares it.
`timescale 1ns / 1ps
module i2c_register_access_sequencer_unit_checker
	import irsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	irsu_item_if        item,
	irsu_result_if      result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_PRE,
		SEQ_STATUS,
		SEQ_LOW,
		SEQ_HIGH
	} seq_phase_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  bus_offset;
		logic [15:0] bus_wdata;
		logic [1:0]  error;
		logic [31:0] result_data;
		logic        last;
	} bus_op_t;

	bus_op_t     expected_ops[$];
	seq_phase_t  seq_phase;
	logic [7:0]  poll_limit;
	logic [7:0]  busy_polls;
	logic [1:0]  job_op;
	logic [2:0]  job_bytes;
	logic [6:0]  job_addr;
	logic [31:0] rx_low;
	int          results_seen;

	function automatic logic [15:0] control_for(input logic rd, input logic [2:0] b,
		input logic [6:0] a);
		logic [15:0] w;
		w = {1'b0, a, 8'h80} | {11'd0, b, 2'b00};
		if (rd)
			w = w | 16'h0010;
		return w;
	endfunction

	function automatic logic [31:0] byte_mask(input logic [2:0] b);
		return b[0] ? 32'h0000_00ff : 32'h0000_ffff;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fail_count++;
		$display("MISMATCH t=%0t result #%0d %s: got 0x%0h, expected 0x%0h",
			$time, results_seen, what, got, want);
	endtask

	task automatic add_access(input logic [1:0] k, input logic [7:0] ofs,
		input logic [15:0] wd, input logic [1:0] err, input logic [31:0] data);
		bus_op_t entry;
		entry = '{k, ofs, wd, err, data, 1'b0};
		expected_ops.insert(expected_ops.size(), entry);
	endtask

	// Applies one accepted input transaction and queues the accesses it causes.
	task automatic advance_sequencer();
		int          before_n;
		logic [31:0] d;
		logic [6:0]  a;
		logic [2:0]  b;
		logic [31:0] rd;
		before_n = expected_ops.size();
		rd = item.rdata;
		if (item.kind == KIND_CMD) begin
			if (seq_phase != SEQ_IDLE) begin
				add_access(OUT_FINISHED, 8'h00, 16'h0000, ERR_BUSY, 32'h0);
			end else begin
				busy_polls = 8'd0;
				job_op = item.op;
				a = item.i2c_addr;
				b = item.byte_count;
				if (item.op == OP_REG_READ || item.op == OP_REG_WRITE) begin
					a = {1'b1, item.conv_sel, item.reg_index};
					b = (item.op == OP_REG_READ) ? 3'd2 : 3'd3;
				end
				job_bytes = b;
				job_addr = a;
				case (item.op)
					OP_RAW_READ: begin
						add_access(OUT_BUS_WRITE, OFS_CTRL, control_for(1'b1, b, a),
							ERR_OK, 32'h0);
						seq_phase = SEQ_STATUS;
					end
					OP_REG_READ: begin
						add_access(OUT_BUS_WRITE, OFS_DATA_LO, 16'h0000, ERR_OK, 32'h0);
						add_access(OUT_BUS_WRITE, OFS_CTRL, control_for(1'b0, 3'd1, a),
							ERR_OK, 32'h0);
						seq_phase = SEQ_PRE;
					end
					default: begin
						d = (item.op == OP_REG_WRITE) ? (item.wdata << 8) : item.wdata;
						add_access(OUT_BUS_WRITE, OFS_DATA_LO, d[15:0], ERR_OK, 32'h0);
						if (b > 3'd2)
							add_access(OUT_BUS_WRITE, OFS_DATA_HI, d[31:16], ERR_OK, 32'h0);
						add_access(OUT_BUS_WRITE, OFS_CTRL, control_for(1'b0, b, a),
							ERR_OK, 32'h0);
						seq_phase = SEQ_STATUS;
					end
				endcase
				add_access(OUT_BUS_READ, OFS_STATUS, 16'h0000, ERR_OK, 32'h0);
			end
		end else begin
			case (seq_phase)
				SEQ_PRE, SEQ_STATUS: begin
					if (rd[0]) begin
						busy_polls = busy_polls + 8'd1;
						if (busy_polls >= poll_limit) begin
							add_access(OUT_FINISHED, 8'h00, 16'h0000, ERR_TIMEOUT, 32'h0);
							seq_phase = SEQ_IDLE;
						end else begin
							add_access(OUT_BUS_READ, OFS_STATUS, 16'h0000, ERR_OK, 32'h0);
						end
					end else if (rd[3]) begin
						add_access(OUT_FINISHED, 8'h00, 16'h0000, ERR_NACK, 32'h0);
						seq_phase = SEQ_IDLE;
					end else if (seq_phase == SEQ_PRE) begin
						busy_polls = 8'd0;
						add_access(OUT_BUS_WRITE, OFS_CTRL,
							control_for(1'b1, job_bytes, job_addr), ERR_OK, 32'h0);
						add_access(OUT_BUS_READ, OFS_STATUS, 16'h0000, ERR_OK, 32'h0);
						seq_phase = SEQ_STATUS;
					end else if (job_op == OP_RAW_WRITE || job_op == OP_REG_WRITE) begin
						add_access(OUT_FINISHED, 8'h00, 16'h0000, ERR_OK, 32'h0);
						seq_phase = SEQ_IDLE;
					end else begin
						add_access(OUT_BUS_READ, OFS_RX_LO, 16'h0000, ERR_OK, 32'h0);
						seq_phase = SEQ_LOW;
					end
				end
				SEQ_LOW: begin
					rx_low = rd;
					if (job_bytes > 3'd2) begin
						add_access(OUT_BUS_READ, OFS_RX_HI, 16'h0000, ERR_OK, 32'h0);
						seq_phase = SEQ_HIGH;
					end else begin
						add_access(OUT_FINISHED, 8'h00, 16'h0000, ERR_OK,
							rd & byte_mask(job_bytes));
						seq_phase = SEQ_IDLE;
					end
				end
				SEQ_HIGH: begin
					add_access(OUT_FINISHED, 8'h00, 16'h0000, ERR_OK,
						rx_low | ((rd & byte_mask(job_bytes)) << 16));
					seq_phase = SEQ_IDLE;
				end
				default: ;
			endcase
		end
		if (expected_ops.size() > before_n)
			expected_ops[expected_ops.size() - 1].last = 1'b1;
	endtask

	task automatic check_result();
		bus_op_t want;
		results_seen++;
		if (expected_ops.size() == 0) begin
			report_mismatch("result with nothing expected, out_kind", result.out_kind, 0);
		end else begin
			want = expected_ops.pop_front();
			if (result.out_kind !== want.out_kind)
				report_mismatch("out_kind", result.out_kind, want.out_kind);
			if (result.bus_offset !== want.bus_offset)
				report_mismatch("bus_offset", result.bus_offset, want.bus_offset);
			if (result.bus_wdata !== want.bus_wdata)
				report_mismatch("bus_wdata", result.bus_wdata, want.bus_wdata);
			if (result.error !== want.error)
				report_mismatch("error", result.error, want.error);
			if (result.result_data !== want.result_data)
				report_mismatch("result_data", result.result_data, want.result_data);
			if (result.last !== want.last)
				report_mismatch("last", result.last, want.last);
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		results_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_ops.delete();
			seq_phase = SEQ_IDLE;
			poll_limit = POLL_LIMIT_RESET;
			busy_polls = 8'd0;
			job_op = OP_RAW_READ;
			job_bytes = 3'd0;
			job_addr = 7'd0;
			rx_low = 32'h0;
			pending = 0;
		end else begin
			if (psel && penable && pready && paddr == CFG_ADDR_POLL_LIMIT) begin
				if (pwrite)
					poll_limit = pwdata[7:0];
				else if (prdata[7:0] !== poll_limit)
					report_mismatch("poll_limit readback", prdata, poll_limit);
			end
			if (item.valid && item.ready)
				advance_sequencer();
			if (result.valid && result.ready)
				check_result();
			pending = expected_ops.size();
		end
	end

endmodule

@@ verif/i2c_register_access_sequencer_unit_test.sv @@
// Testbench top of the I2C register access sequencer: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module i2c_register_access_sequencer_unit_test;
	import irsu_pkg::*;

	// Clock, reset and the configuration port. The block itself only ever sees
	// values driven here; all prediction lives in the checker instance.
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	irsu_item_if   item_ch();
	irsu_result_if result_ch();

	// Pacing controls shared by the sender and the receiver processes.
	bit          idle_on;
	bit          hold_pending;
	bit          allow_timeouts;
	logic [7:0]  limit_now;
	int          items_sent;
	int          stray_count;
	int          settings_used;

	i2c_register_access_sequencer_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	i2c_register_access_sequencer_unit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offers one input transaction and returns at the edge where it is accepted.
	// Valid stays high afterwards, so back-to-back transactions never toggle it
	// within one time step; a random gap lowers it first when idling is enabled.
	task automatic send_item(input logic kind, input logic [1:0] op,
		input logic [2:0] bytes, input logic [6:0] addr, input logic side,
		input logic [4:0] reg_idx, input logic [31:0] wd, input logic [31:0] rd);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.kind       <= kind;
		item_ch.op         <= op;
		item_ch.byte_count <= bytes;
		item_ch.i2c_addr   <= addr;
		item_ch.conv_sel   <= side;
		item_ch.reg_index  <= reg_idx;
		item_ch.wdata      <= wd;
		item_ch.rdata      <= rd;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// A command transaction; the unused rdata field carries random bits.
	task automatic send_cmd(input logic [1:0] op, input logic [2:0] bytes,
		input logic [6:0] addr, input logic side, input logic [4:0] reg_idx,
		input logic [31:0] wd);
		send_item(KIND_CMD, op, bytes, addr, side, reg_idx, wd, $urandom());
	endtask

	// A bus response transaction; the command fields carry random bits, since
	// the block must ignore them for this kind.
	task automatic send_resp(input logic [31:0] rd);
		send_item(KIND_RESP, 2'($urandom()), 3'($urandom()), 7'($urandom()),
			1'($urandom()), 5'($urandom()), $urandom(), rd);
	endtask

	// Fully random command. Byte counts mostly stay in the legal 1..4 range, but
	// every 3-bit value shows up now and then.
	task automatic send_random_cmd();
		logic [2:0] bytes;
		bytes = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		send_cmd(2'($urandom_range(0, 3)), bytes, 7'($urandom_range(0, 127)),
			1'($urandom()), 5'($urandom()), $urandom());
	endtask

	// While a transfer is in flight, another command now and then collides with
	// it and must be answered with a busy error, leaving the transfer intact.
	task automatic maybe_collide();
		if ($urandom_range(0, 15) == 0)
			send_random_cmd();
	endtask

	// Plays one status polling round: some busy reads, then either an idle
	// status (passed), a missing acknowledge, or enough busy reads for a timeout.
	task automatic run_status(output bit passed);
		int eff;
		int busy_n;
		bit to;
		eff = (limit_now == 8'd0) ? 1 : int'(limit_now);
		to = allow_timeouts && eff <= 16 && $urandom_range(0, 5) == 0;
		busy_n = to ? eff : $urandom_range(0, (eff - 1 < 3) ? eff - 1 : 3);
		for (int i = 0; i < busy_n; i++) begin
			maybe_collide();
			send_resp($urandom() | 32'h0000_0001);
		end
		// After a timeout the block is idle again, so no collision is tried.
		if (!to)
			maybe_collide();
		if (to) begin
			passed = 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			send_resp(($urandom() | 32'h0000_0008) & ~32'h0000_0001);
			passed = 1'b0;
		end else begin
			send_resp($urandom() & ~32'h0000_0009);
			passed = 1'b1;
		end
	endtask

	// One complete, well-formed transfer with random content: the command, the
	// status rounds it needs, and the data responses of a read.
	task automatic run_transfer();
		logic [1:0] op;
		logic [2:0] bytes;
		bit         ok;
		op = 2'($urandom_range(0, 3));
		bytes = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		// Now and then a response arrives while the block is idle; it is dropped.
		if ($urandom_range(0, 9) == 0) begin
			send_resp($urandom());
			stray_count++;
		end
		send_cmd(op, bytes, 7'($urandom_range(0, 127)), 1'($urandom()), 5'($urandom()),
			$urandom());
		if (op == OP_REG_READ) begin
			run_status(ok);
			if (!ok)
				return;
		end
		run_status(ok);
		if (!ok)
			return;
		if (op == OP_RAW_READ || op == OP_REG_READ) begin
			maybe_collide();
			send_resp($urandom());
			if (op == OP_RAW_READ && bytes > 3'd2) begin
				maybe_collide();
				send_resp($urandom());
			end
		end
	endtask

	// Stops offering, waits until every predicted result has come back, then a
	// few more cycles for transactions that cause no result.
	task automatic wait_quiet();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready; the register
	// takes the value at the edge where the access completes.
	task automatic apb_write(input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_POLL_LIMIT;
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		limit_now = value;
		settings_used++;
		@(posedge clk);
	endtask

	// APB read; the checker compares prdata at the completing edge.
	task automatic apb_read();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= CFG_ADDR_POLL_LIMIT;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: ready comes in random stretches. A requested hold-off keeps it
	// low for a long, counted stretch so that the job queue fills and the block
	// has to stall its input side.
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Stimulus: directed cases at the reset poll limit, then random phases, each
	// under its own poll limit, then the drain and the verdict.
	initial begin : stimulus
		logic [7:0] settings[7];
		int         phase_start;
		int         drain;
		bit         held;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= CFG_ADDR_POLL_LIMIT;
		pwdata             <= 32'd0;
		item_ch.valid      <= 1'b0;
		item_ch.kind       <= KIND_CMD;
		item_ch.op         <= OP_RAW_READ;
		item_ch.byte_count <= 3'd0;
		item_ch.i2c_addr   <= 7'd0;
		item_ch.conv_sel   <= 1'b0;
		item_ch.reg_index  <= 5'd0;
		item_ch.wdata      <= 32'd0;
		item_ch.rdata      <= 32'd0;
		idle_on = 1'b1;
		hold_pending = 1'b0;
		allow_timeouts = 1'b1;
		limit_now = POLL_LIMIT_RESET;
		items_sent = 0;
		stray_count = 0;
		settings_used = 0;
		held = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset poll limit.
		// Raw write of four bytes to the top address with all data bits set.
		send_cmd(OP_RAW_WRITE, 3'd4, 7'h7f, 1'b0, 5'd0, 32'hffff_ffff);
		send_resp(32'h0000_0000);
		// Raw read of four bytes: both receive registers are fetched.
		send_cmd(OP_RAW_READ, 3'd4, 7'h00, 1'b1, 5'd31, 32'h0);
		send_resp(32'h0000_0000);
		send_resp(32'hffff_ffff);
		send_resp(32'hffff_ffff);
		// Odd count above two: the upper half uses the one-byte mask.
		send_cmd(OP_RAW_READ, 3'd3, 7'h55, 1'b0, 5'd0, 32'h0);
		send_resp(32'hffff_fff6);
		send_resp(32'ha5a5_a5a5);
		send_resp(32'h1234_5678);
		// Register write: data is shifted up by a byte and truncated to 32 bits.
		send_cmd(OP_REG_WRITE, 3'd0, 7'h00, 1'b1, 5'd31, 32'hffff_ffff);
		send_resp(32'h0000_0000);
		// Register read: pointer write round, then the two-byte read round.
		send_cmd(OP_REG_READ, 3'd7, 7'h7f, 1'b0, 5'd0, 32'h0);
		send_resp(32'h0000_0000);
		send_resp(32'h0000_0000);
		send_resp(32'hffff_ffff);
		// A busy status, a command that collides with the transfer, then a NACK.
		send_cmd(OP_RAW_READ, 3'd1, 7'h01, 1'b0, 5'd0, 32'h0);
		send_resp(32'h0000_0001);
		send_cmd(OP_RAW_WRITE, 3'd2, 7'h22, 1'b1, 5'd3, 32'h5a5a_5a5a);
		send_resp(32'h0000_0008);
		// NACK already in the pointer round of a register read.
		send_cmd(OP_REG_READ, 3'd2, 7'h10, 1'b1, 5'd5, 32'h0);
		send_resp(32'hffff_fff8 & ~32'h0000_0001);
		// Count of seven: ORed into the control word, upper registers in use.
		send_cmd(OP_RAW_READ, 3'd7, 7'h3c, 1'b0, 5'd0, 32'h0);
		send_resp(32'h0000_0000);
		send_resp(32'h8765_4321);
		send_resp(32'hffff_ffff);

		// Random part. The settings include both ends of the poll limit and zero,
		// which behaves like one; the small limits also run into timeouts.
		settings = '{8'd3, 8'd255, 8'd1, 8'd0, 8'($urandom_range(4, 254)), 8'd100, 8'd2};
		for (int p = 0; p < 7; p++) begin
			// The sender pauses here until every expected result has come back, so
			// the register is only ever changed while the block is idle.
			idle_on = 1'b0;
			wait_quiet();
			apb_write(settings[p]);
			apb_read();
			idle_on = (p % 3 != 2) && (p != 6);
			phase_start = items_sent - stray_count;
			while (items_sent - stray_count - phase_start < 40) begin
				// One long receiver hold-off while the sender keeps offering work.
				if (p == 2 && !held && items_sent - stray_count - phase_start >= 10) begin
					hold_pending = 1'b1;
					held = 1'b1;
				end
				run_transfer();
			end
		end
		item_ch.valid <= 1'b0;

		// Drain: wait for every expected result, with a bound.
		@(posedge clk);
		drain = 0;
		while (pending != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		if (pending != 0) begin
			$display("Drain timed out with %0d results still expected.", pending);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			repeat (16) @(posedge clk);
			$display("Sent %0d transactions (%0d dropped responses) under %0d poll limits,",
				items_sent, stray_count, settings_used + 1);
			$display("covering all four operations, busy, NACK, timeout and busy-command cases.");
			if (fail_count == 0)
				$display("RESULT: OK");
			else
				$display("RESULT: ERROR");
			$finish;
		end
	end

	// Watchdog, far above the slowest correct run.
	initial begin
		#8_000_000;
		$display("Watchdog expired before the run completed.");
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ i2c_register_access_sequencer_unit.f @@
design/irsu_pkg.sv
design/irsu_if.sv
design/irsu_queue.sv
design/irsu_front.sv
design/irsu_back.sv
design/i2c_register_access_sequencer_unit.sv
verif/i2c_register_access_sequencer_unit_checker.sv
verif/i2c_register_access_sequencer_unit_test.sv
